/* sv/realtime_command_recognizer_top_assert.svh */
// Assertion macros shared by the recognizer RTL.
`ifndef REALTIME_COMMAND_RECOGNIZER_TOP_ASSERT_SVH
`define REALTIME_COMMAND_RECOGNIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/rcr_pkg.sv */
package rcr_pkg;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'd0,
		ST_DLE      = 4'd1,
		ST_DLE_EOT  = 4'd2,
		ST_ESC      = 4'd3,
		ST_PULSE_M  = 4'd4,
		ST_PULSE_T1 = 4'd5,
		ST_PULSE_T2 = 4'd6,
		ST_GS       = 4'd7,
		ST_GS_LP    = 4'd8,
		ST_LEN_LO   = 4'd9,
		ST_LEN_HI   = 4'd10,
		ST_FN       = 4'd11,
		ST_SKIP     = 4'd12,
		ST_TASK_Q   = 4'd13,
		ST_TASK_D   = 4'd14,
		ST_GS_I     = 4'd15
	} parse_state_t;

	typedef enum logic [2:0] {
		EV_STATUS       = 3'd0,
		EV_PULSE        = 3'd1,
		EV_QUERY_STATUS = 3'd2,
		EV_LAST_TASK    = 3'd3,
		EV_TASK_STATE   = 3'd4,
		EV_CLEAR_PAPER  = 3'd5,
		EV_DELETE_TASK  = 3'd6,
		EV_PRINTER_ID   = 3'd7
	} event_t;

	localparam logic [7:0] CH_DLE   = 8'h10;
	localparam logic [7:0] CH_EOT   = 8'h04;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_GS    = 8'h1D;
	localparam logic [7:0] CH_PULSE = 8'h70;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_ID    = 8'h49;
	localparam logic [7:0] CH_T     = 8'h54;

	localparam logic [7:0] SEL_PRINTER = 8'd1;
	localparam logic [7:0] SEL_OFFLINE = 8'd2;
	localparam logic [7:0] SEL_ERROR   = 8'd3;
	localparam logic [7:0] SEL_PAPER   = 8'd4;

	localparam logic [7:0] FN_QUERY_STATUS = 8'd1;
	localparam logic [7:0] FN_LAST_TASK    = 8'd2;
	localparam logic [7:0] FN_TASK_STATE   = 8'd3;
	localparam logic [7:0] FN_CLEAR_PAPER  = 8'd4;
	localparam logic [7:0] FN_DELETE_TASK  = 8'd5;

	localparam logic [7:0]  STATUS_BASE   = 8'h12;
	localparam logic [15:0] TASK_ID_BYTES = 16'd4;

endpackage

/* sv/rcr_if.sv */
interface rcr_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_buffer;
	logic [7:0] channel;
	logic       drawer_open;
	logic       platen_open;
	logic       paper_out;
	logic       paper_jammed;
	logic       head_hot;
	logic       motor_hot;
	logic       paper_low;

	modport source (
		output valid, data_byte, first_of_buffer, channel, drawer_open, platen_open,
			paper_out, paper_jammed, head_hot, motor_hot, paper_low,
		input  ready
	);
	modport sink (
		input  valid, data_byte, first_of_buffer, channel, drawer_open, platen_open,
			paper_out, paper_jammed, head_hot, motor_hot, paper_low,
		output ready
	);
endinterface

interface rcr_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  status_byte;
	logic [31:0] task_or_pin;
	logic [8:0]  on_time;
	logic [8:0]  off_time;
	logic [7:0]  reply_channel;

	modport source (
		output valid, event_res, status_byte, task_or_pin, on_time, off_time, reply_channel,
		input  ready
	);
	modport sink (
		input  valid, event_res, status_byte, task_or_pin, on_time, off_time, reply_channel,
		output ready
	);
endinterface

/* sv/realtime_command_recognizer_top.sv */
// Channel  Direction  Carries
// -------  ---------  ------------------------------------------------------
// cmd      in         one host byte, buffer-start flag, channel, sensor flags
// evt      out        one recognized event with its arguments
//
// Each byte is parsed in the cycle of its transfer; the parse state registers
// hold the command context and the event register holds the result.
// A new byte is taken every cycle while the event register is empty or drains.
// A stalled event holds off all bytes until it drains; at most one event per byte.
// arst_n clears the parse state and the event valid flag.
`include "realtime_command_recognizer_top_assert.svh"

module realtime_command_recognizer_top (
	input logic clk,
	input logic arst_n,
	rcr_cmd_if.sink   cmd,
	rcr_evt_if.source evt
);
	import rcr_pkg::*;

	parse_state_t state_q, state_d, state_cur;
	logic [15:0]  rem_q, rem_d, rem_full, len_m1;
	logic [1:0]   cnt_q, cnt_d;
	logic [31:0]  acc_q, acc_d, acc_ins;
	logic [7:0]   pin_q, pin_d;
	logic [7:0]   pon_q, pon_d;

	logic        emit;
	event_t      ev;
	logic [7:0]  stat;
	logic [31:0] arg;
	logic [8:0]  ont, offt;

	logic        evt_valid_q;
	event_t      ev_q;
	logic [7:0]  stat_q;
	logic [31:0] arg_q;
	logic [8:0]  ont_q, offt_q;
	logic [7:0]  chn_q;

	logic        cmd_fire;
	logic [7:0]  d;

	assign cmd.ready = !evt_valid_q || evt.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign d         = cmd.data_byte;

	always_comb begin
		state_cur = cmd.first_of_buffer ? ST_IDLE : state_q;
		state_d   = state_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		pin_d     = pin_q;
		pon_d     = pon_q;
		emit      = 1'b0;
		ev        = EV_STATUS;
		stat      = 8'd0;
		arg       = 32'd0;
		ont       = 9'd0;
		offt      = 9'd0;
		rem_full  = {d, rem_q[7:0]};
		len_m1    = rem_q - 16'd1;
		acc_ins   = acc_q;
		acc_ins[{cnt_q, 3'b000} +: 8] = d;

		if (cmd.first_of_buffer) begin
			state_d = ST_IDLE;
			rem_d   = 16'd0;
			cnt_d   = 2'd0;
			acc_d   = 32'd0;
		end

		case (state_cur)
			ST_IDLE: begin
				if (d == CH_DLE) begin
					state_d = ST_DLE;
				end else if (d == CH_ESC) begin
					state_d = ST_ESC;
				end else if (d == CH_GS) begin
					state_d = ST_GS;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DLE:  state_d = (d == CH_EOT) ? ST_DLE_EOT : ST_IDLE;
			ST_DLE_EOT: begin
				state_d = ST_IDLE;
				stat    = STATUS_BASE;
				emit    = 1'b1;
				case (d)
					SEL_PRINTER: stat[2] = cmd.drawer_open;
					SEL_OFFLINE: begin
						stat[2] = cmd.platen_open;
						stat[6] = cmd.paper_out;
					end
					SEL_ERROR: begin
						stat[2] = cmd.paper_out | cmd.platen_open;
						stat[5] = cmd.paper_jammed;
						stat[6] = cmd.head_hot | cmd.motor_hot;
					end
					SEL_PAPER: begin
						stat[3:2] = {2{cmd.paper_low}};
						stat[6:5] = {2{cmd.paper_out}};
					end
					default: emit = 1'b0;
				endcase
			end
			ST_ESC:      state_d = (d == CH_PULSE) ? ST_PULSE_M : ST_IDLE;
			ST_PULSE_M: begin
				pin_d   = d;
				state_d = ST_PULSE_T1;
			end
			ST_PULSE_T1: begin
				pon_d   = d;
				state_d = ST_PULSE_T2;
			end
			ST_PULSE_T2: begin
				emit    = 1'b1;
				ev      = EV_PULSE;
				arg     = {24'd0, pin_q};
				ont     = {pon_q, 1'b0};
				offt    = {d, 1'b0};
				state_d = ST_IDLE;
			end
			ST_GS: begin
				if (d == CH_LPAR) begin
					state_d = ST_GS_LP;
				end else if (d == CH_ID) begin
					state_d = ST_GS_I;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_GS_I: begin
				emit    = 1'b1;
				ev      = EV_PRINTER_ID;
				arg     = {24'd0, d};
				state_d = ST_IDLE;
			end
			ST_GS_LP:  state_d = (d == CH_T) ? ST_LEN_LO : ST_IDLE;
			ST_LEN_LO: begin
				rem_d   = {8'd0, d};
				state_d = ST_LEN_HI;
			end
			ST_LEN_HI: begin
				if (rem_full == 16'd0) begin
					state_d = ST_IDLE;
					rem_d   = 16'd0;
				end else begin
					state_d = ST_FN;
					rem_d   = rem_full;
				end
			end
			ST_FN: begin
				// Anything that does not fit its expected length skips the
				// remaining parameter bytes without an event.
				if (d == FN_QUERY_STATUS || d == FN_LAST_TASK || d == FN_CLEAR_PAPER) begin
					if (len_m1 != 16'd0) begin
						rem_d   = len_m1;
						state_d = ST_SKIP;
					end else begin
						emit    = 1'b1;
						ev      = (d == FN_QUERY_STATUS) ? EV_QUERY_STATUS :
							(d == FN_LAST_TASK) ? EV_LAST_TASK : EV_CLEAR_PAPER;
						rem_d   = 16'd0;
						state_d = ST_IDLE;
					end
				end else if ((d == FN_TASK_STATE || d == FN_DELETE_TASK) &&
						len_m1 == TASK_ID_BYTES) begin
					acc_d   = 32'd0;
					cnt_d   = 2'd0;
					rem_d   = len_m1;
					state_d = (d == FN_TASK_STATE) ? ST_TASK_Q : ST_TASK_D;
				end else if (len_m1 != 16'd0) begin
					rem_d   = len_m1;
					state_d = ST_SKIP;
				end else begin
					rem_d   = 16'd0;
					state_d = ST_IDLE;
				end
			end
			ST_SKIP: begin
				rem_d = len_m1;
				if (len_m1 == 16'd0) begin
					state_d = ST_IDLE;
				end
			end
			ST_TASK_Q, ST_TASK_D: begin
				// The task id arrives least significant byte first.
				acc_d = acc_ins;
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					emit    = 1'b1;
					ev      = (state_cur == ST_TASK_Q) ? EV_TASK_STATE : EV_DELETE_TASK;
					arg     = acc_ins;
					state_d = ST_IDLE;
					rem_d   = 16'd0;
					cnt_d   = 2'd0;
					acc_d   = 32'd0;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= 16'd0;
			cnt_q   <= 2'd0;
			acc_q   <= 32'd0;
			pin_q   <= 8'd0;
			pon_q   <= 8'd0;
		end else if (cmd_fire) begin
			state_q <= state_d;
			rem_q   <= rem_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			pin_q   <= pin_d;
			pon_q   <= pon_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			evt_valid_q <= emit;
		end else if (evt.ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire && emit) begin
			ev_q   <= ev;
			stat_q <= stat;
			arg_q  <= arg;
			ont_q  <= ont;
			offt_q <= offt;
			chn_q  <= cmd.channel;
		end
	end

	assign evt.valid         = evt_valid_q;
	assign evt.event_res     = ev_q;
	assign evt.status_byte   = stat_q;
	assign evt.task_or_pin   = arg_q;
	assign evt.on_time       = ont_q;
	assign evt.off_time      = offt_q;
	assign evt.reply_channel = chn_q;

	`RCR_ASSERT_IMPLY(a_no_take_when_blocked, clk, arst_n,
		evt.valid && !evt.ready, !cmd.ready, "byte taken while an event is stalled")
	`RCR_ASSERT_IMPLY(a_skip_nonzero, clk, arst_n,
		state_q == ST_SKIP, rem_q != 16'd0, "skip state with zero remaining length")
	`RCR_ASSERT_IMPLY(a_times_even, clk, arst_n,
		evt.valid, !evt.on_time[0] && !evt.off_time[0], "pulse time is not doubled")
	`RCR_ASSERT_NEXT(a_buffer_start_idle, clk, arst_n,
		cmd_fire && cmd.first_of_buffer && cmd.data_byte != CH_DLE &&
			cmd.data_byte != CH_ESC && cmd.data_byte != CH_GS,
		state_q == ST_IDLE, "buffer start did not return the parser to idle")

endmodule

/* test/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcr_pkg::*;

	typedef struct {
		logic [7:0] data_byte;
		logic       first_of_buffer;
		logic [7:0] channel;
		logic       drawer_open;
		logic       platen_open;
		logic       paper_out;
		logic       paper_jammed;
		logic       head_hot;
		logic       motor_hot;
		logic       paper_low;
	} host_byte_t;

	typedef struct {
		event_t      code;
		logic [7:0]  status_byte;
		logic [31:0] task_or_pin;
		logic [8:0]  on_time;
		logic [8:0]  off_time;
		logic [7:0]  reply_channel;
	} printer_event_t;

	logic clk = 1'b0;
	logic arst_n;

	rcr_cmd_if cmd();
	rcr_evt_if evt();

	realtime_command_recognizer_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.evt   (evt)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	host_byte_t     tx_bytes[$];
	printer_event_t events_due[$];
	int             bytes_queued = 0;
	int             bytes_accepted = 0;
	int             mismatch_count = 0;
	int             src_idle_pct = 15;
	int             snk_idle_pct = 58;
	bit             cmd_taken = 1'b0;
	bit             restart_next = 1'b0;

	// Parser shadow state.
	parse_state_t   prs_state = ST_IDLE;
	logic [15:0]    len_left = '0;
	logic [15:0]    id_seen = '0;
	logic [31:0]    id_accum = '0;
	logic [7:0]     pin_sel = '0;
	logic [7:0]     on_ticks = '0;

	function automatic void clear_parse();
		prs_state = ST_IDLE;
		len_left = '0;
		id_seen = '0;
		id_accum = '0;
	endfunction

	function automatic void skip_rest(input logic [15:0] n);
		if (n != 16'd0) begin
			len_left = n;
			prs_state = ST_SKIP;
		end else begin
			clear_parse();
		end
	endfunction

	function automatic bit predict_event(input host_byte_t hb, output printer_event_t ev);
		logic [7:0]  d;
		logic [7:0]  st;
		logic [15:0] len;
		d = hb.data_byte;
		ev.code = EV_STATUS;
		ev.status_byte = '0;
		ev.task_or_pin = '0;
		ev.on_time = '0;
		ev.off_time = '0;
		ev.reply_channel = hb.channel;
		predict_event = 1'b0;
		if (hb.first_of_buffer)
			clear_parse();
		case (prs_state)
		ST_IDLE: begin
			if (d == CH_DLE) prs_state = ST_DLE;
			else if (d == CH_ESC) prs_state = ST_ESC;
			else if (d == CH_GS) prs_state = ST_GS;
			else clear_parse();
		end
		ST_DLE: begin
			if (d == CH_EOT) prs_state = ST_DLE_EOT;
			else clear_parse();
		end
		ST_DLE_EOT: begin
			clear_parse();
			st = STATUS_BASE;
			predict_event = 1'b1;
			case (d)
			SEL_PRINTER: st[2] = hb.drawer_open;
			SEL_OFFLINE: begin
				st[2] = hb.platen_open;
				st[6] = hb.paper_out;
			end
			SEL_ERROR: begin
				st[2] = hb.paper_out | hb.platen_open;
				st[5] = hb.paper_jammed;
				st[6] = hb.head_hot | hb.motor_hot;
			end
			SEL_PAPER: begin
				if (hb.paper_low) st[3:2] = 2'b11;
				if (hb.paper_out) st[6:5] = 2'b11;
			end
			default: predict_event = 1'b0;
			endcase
			ev.status_byte = st;
		end
		ST_ESC: begin
			if (d == CH_PULSE) prs_state = ST_PULSE_M;
			else clear_parse();
		end
		ST_PULSE_M: begin
			pin_sel = d;
			prs_state = ST_PULSE_T1;
		end
		ST_PULSE_T1: begin
			on_ticks = d;
			prs_state = ST_PULSE_T2;
		end
		ST_PULSE_T2: begin
			ev.code = EV_PULSE;
			ev.task_or_pin = {24'h0, pin_sel};
			ev.on_time = {on_ticks, 1'b0};
			ev.off_time = {d, 1'b0};
			predict_event = 1'b1;
			clear_parse();
		end
		ST_GS: begin
			if (d == CH_LPAR) prs_state = ST_GS_LP;
			else if (d == CH_ID) prs_state = ST_GS_I;
			else clear_parse();
		end
		ST_GS_I: begin
			ev.code = EV_PRINTER_ID;
			ev.task_or_pin = {24'h0, d};
			predict_event = 1'b1;
			clear_parse();
		end
		ST_GS_LP: begin
			if (d == CH_T) prs_state = ST_LEN_LO;
			else clear_parse();
		end
		ST_LEN_LO: begin
			len_left = {8'h00, d};
			prs_state = ST_LEN_HI;
		end
		ST_LEN_HI: begin
			len_left = {d, len_left[7:0]};
			if (len_left == 16'd0) clear_parse();
			else prs_state = ST_FN;
		end
		ST_FN: begin
			len = len_left - 16'd1;
			if (d == FN_QUERY_STATUS || d == FN_LAST_TASK || d == FN_CLEAR_PAPER) begin
				if (len != 16'd0) begin
					skip_rest(len);
				end else begin
					clear_parse();
					predict_event = 1'b1;
					ev.code = (d == FN_QUERY_STATUS) ? EV_QUERY_STATUS :
						(d == FN_LAST_TASK) ? EV_LAST_TASK : EV_CLEAR_PAPER;
				end
			end else if ((d == FN_TASK_STATE || d == FN_DELETE_TASK) &&
					len == TASK_ID_BYTES) begin
				id_accum = '0;
				id_seen = '0;
				len_left = len;
				prs_state = (d == FN_TASK_STATE) ? ST_TASK_Q : ST_TASK_D;
			end else begin
				skip_rest(len);
			end
		end
		ST_SKIP: begin
			len_left = len_left - 16'd1;
			if (len_left == 16'd0) clear_parse();
		end
		ST_TASK_Q, ST_TASK_D: begin
			// The task id arrives least significant byte first.
			id_accum = id_accum | ({24'h0, d} << {id_seen[1:0], 3'b000});
			id_seen = id_seen + 16'd1;
			if (id_seen >= TASK_ID_BYTES) begin
				ev.code = (prs_state == ST_TASK_Q) ? EV_TASK_STATE : EV_DELETE_TASK;
				ev.task_or_pin = id_accum;
				predict_event = 1'b1;
				clear_parse();
			end
		end
		default: clear_parse();
		endcase
	endfunction

	task automatic report_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			report_error($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
	endtask

	task automatic queue_byte(input logic [7:0] d, input logic fob, input logic [6:0] sensors,
			input logic [7:0] chan);
		host_byte_t hb;
		hb.data_byte = d;
		hb.first_of_buffer = fob;
		hb.channel = chan;
		{hb.paper_low, hb.motor_hot, hb.head_hot, hb.paper_jammed, hb.paper_out,
			hb.platen_open, hb.drawer_open} = sensors;
		tx_bytes.push_back(hb);
		bytes_queued++;
	endtask

	task automatic queue_rand(input logic [7:0] d, input logic fob);
		queue_byte(d, fob, 7'($urandom_range(127)), 8'($urandom_range(255)));
	endtask

	task automatic queue_len_header(input logic [7:0] pl, input logic [7:0] ph, input logic fob);
		queue_rand(CH_GS, fob);
		queue_rand(CH_LPAR, 1'b0);
		queue_rand(CH_T, 1'b0);
		queue_rand(pl, 1'b0);
		queue_rand(ph, 1'b0);
	endtask

	task automatic queue_command();
		int         len;
		logic       fob;
		logic [7:0] fn;
		fob = restart_next || ($urandom_range(3) == 0);
		restart_next = 1'b0;
		case ($urandom_range(11))
		0, 1, 2: begin
			queue_rand(CH_DLE, fob);
			queue_rand(CH_EOT, 1'b0);
			if ($urandom_range(3) == 0) queue_rand(8'($urandom_range(255)), 1'b0);
			else queue_rand(8'($urandom_range(SEL_PAPER, SEL_PRINTER)), 1'b0);
		end
		3: begin
			queue_rand(CH_ESC, fob);
			queue_rand(CH_PULSE, 1'b0);
			repeat (3) queue_rand(8'($urandom_range(255)), 1'b0);
		end
		4: begin
			queue_rand(CH_GS, fob);
			queue_rand(CH_ID, 1'b0);
			queue_rand(8'($urandom_range(255)), 1'b0);
		end
		5: begin
			case ($urandom_range(2))
			0: fn = FN_QUERY_STATUS;
			1: fn = FN_LAST_TASK;
			default: fn = FN_CLEAR_PAPER;
			endcase
			queue_len_header(8'd1, 8'd0, fob);
			queue_rand(fn, 1'b0);
		end
		6, 7: begin
			fn = $urandom_range(1) ? FN_TASK_STATE : FN_DELETE_TASK;
			queue_len_header(8'd5, 8'd0, fob);
			queue_rand(fn, 1'b0);
			repeat (4) queue_rand(8'($urandom_range(255)), 1'b0);
		end
		8: begin
			// Arbitrary short length, so mismatched lengths and unknown
			// functions get skipped to the end of the block.
			len = $urandom_range(7);
			fn = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
			queue_len_header(8'(len), 8'd0, fob);
			if (len != 0) begin
				queue_rand(fn, 1'b0);
				repeat (len - 1) queue_rand(8'($urandom_range(255)), 1'b0);
			end
		end
		9: begin
			case ($urandom_range(2))
			0: queue_rand(CH_DLE, fob);
			1: begin
				queue_rand(CH_ESC, fob);
				queue_rand(CH_PULSE, 1'b0);
				queue_rand(8'($urandom_range(255)), 1'b0);
			end
			default: begin
				queue_len_header(8'($urandom_range(255)), 8'($urandom_range(255)), fob);
				repeat ($urandom_range(4)) queue_rand(8'($urandom_range(255)), 1'b0);
			end
			endcase
			// The truncated command is abandoned by a buffer start.
			restart_next = 1'b1;
		end
		default: begin
			repeat ($urandom_range(3, 1))
				queue_rand(8'($urandom_range(255)), 1'($urandom_range(1)));
			restart_next = 1'($urandom_range(1));
		end
		endcase
	endtask

	always @(negedge clk) begin
		host_byte_t hb;
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			evt.ready <= 1'b0;
		end else begin
			if (!cmd.valid || cmd_taken) begin
				if (tx_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					hb = tx_bytes.pop_front();
					cmd.valid <= 1'b1;
					cmd.data_byte <= hb.data_byte;
					cmd.first_of_buffer <= hb.first_of_buffer;
					cmd.channel <= hb.channel;
					cmd.drawer_open <= hb.drawer_open;
					cmd.platen_open <= hb.platen_open;
					cmd.paper_out <= hb.paper_out;
					cmd.paper_jammed <= hb.paper_jammed;
					cmd.head_hot <= hb.head_hot;
					cmd.motor_hot <= hb.motor_hot;
					cmd.paper_low <= hb.paper_low;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
			evt.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Events are checked before the byte of the same edge is predicted, since an
	// event is registered when its last byte is taken and leaves the block after it.
	always @(posedge clk) begin
		host_byte_t     hb;
		printer_event_t want;
		printer_event_t pred;
		cmd_taken = arst_n && ((cmd.valid && cmd.ready) === 1'b1);
		if (arst_n && (evt.valid && evt.ready) === 1'b1) begin
			if (events_due.size() == 0) begin
				report_error($sformatf("unexpected event %0h", evt.event_res));
			end else begin
				want = events_due.pop_front();
				check_field("event_res", 32'(want.code), 32'(evt.event_res));
				check_field("status_byte", 32'(want.status_byte), 32'(evt.status_byte));
				check_field("task_or_pin", want.task_or_pin, evt.task_or_pin);
				check_field("on_time", 32'(want.on_time), 32'(evt.on_time));
				check_field("off_time", 32'(want.off_time), 32'(evt.off_time));
				check_field("reply_channel", 32'(want.reply_channel),
					32'(evt.reply_channel));
			end
		end
		if (cmd_taken) begin
			hb.data_byte = cmd.data_byte;
			hb.first_of_buffer = cmd.first_of_buffer;
			hb.channel = cmd.channel;
			hb.drawer_open = cmd.drawer_open;
			hb.platen_open = cmd.platen_open;
			hb.paper_out = cmd.paper_out;
			hb.paper_jammed = cmd.paper_jammed;
			hb.head_hot = cmd.head_hot;
			hb.motor_hot = cmd.motor_hot;
			hb.paper_low = cmd.paper_low;
			if (predict_event(hb, pred))
				events_due.push_back(pred);
			bytes_accepted++;
		end
	end

	initial begin
		int target;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.data_byte = '0;
		cmd.first_of_buffer = 1'b0;
		cmd.channel = '0;
		cmd.drawer_open = 1'b0;
		cmd.platen_open = 1'b0;
		cmd.paper_out = 1'b0;
		cmd.paper_jammed = 1'b0;
		cmd.head_hot = 1'b0;
		cmd.motor_hot = 1'b0;
		cmd.paper_low = 1'b0;
		evt.ready = 1'b0;

		// Status requests with every sensor set, and an unknown selector.
		queue_byte(CH_DLE, 1'b1, 7'h7F, 8'h00);
		queue_byte(CH_EOT, 1'b0, 7'h7F, 8'h00);
		queue_byte(SEL_PRINTER, 1'b0, 7'h7F, 8'h00);
		queue_byte(CH_DLE, 1'b0, 7'h7F, 8'hFF);
		queue_byte(CH_EOT, 1'b0, 7'h7F, 8'hFF);
		queue_byte(SEL_PAPER, 1'b0, 7'h7F, 8'hFF);
		queue_byte(CH_DLE, 1'b0, 7'h00, 8'h5A);
		queue_byte(CH_EOT, 1'b0, 7'h00, 8'h5A);
		queue_byte(8'h00, 1'b0, 7'h00, 8'h5A);
		// Drawer pulse with the largest arguments.
		queue_byte(CH_ESC, 1'b0, 7'h00, 8'hFF);
		queue_byte(CH_PULSE, 1'b0, 7'h00, 8'hFF);
		queue_byte(8'hFF, 1'b0, 7'h00, 8'hFF);
		queue_byte(8'hFF, 1'b0, 7'h00, 8'hFF);
		queue_byte(8'hFF, 1'b0, 7'h00, 8'hFF);
		queue_byte(CH_GS, 1'b0, 7'h00, 8'h00);
		queue_byte(CH_ID, 1'b0, 7'h00, 8'h00);
		queue_byte(8'h00, 1'b0, 7'h00, 8'h00);
		// A zero length block ends without an event.
		queue_len_header(8'h00, 8'h00, 1'b0);
		// A buffer start abandons the pending DLE.
		queue_byte(CH_DLE, 1'b0, 7'h00, 8'h11);
		queue_byte(CH_GS, 1'b1, 7'h00, 8'h22);
		queue_byte(CH_ID, 1'b0, 7'h00, 8'h22);
		queue_byte(8'h80, 1'b0, 7'h00, 8'h22);

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
			0: begin
				src_idle_pct = 15;
				snk_idle_pct = 58;
			end
			1: begin
				src_idle_pct = 58;
				snk_idle_pct = 15;
			end
			default: begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			endcase
			target = bytes_queued + 160;
			while (bytes_queued < target)
				queue_command();
			while (bytes_accepted != bytes_queued)
				@(posedge clk);
		end

		while (events_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
